>>> rtl/quorum_vote_tracker_defines.svh
// assertion macros shared by the checker files
`ifndef QUORUM_VOTE_TRACKER_DEFINES_SVH
`define QUORUM_VOTE_TRACKER_DEFINES_SVH

// consequent checked in the same cycle
`define QVT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define QVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/qvt_pkg.sv
package qvt_pkg;

    localparam int KEY_W        = 256;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam int DEF_MAX_VOTES     = 128;
    localparam int DEF_HISTORY_DEPTH = 128;

    // quorum is max(1, voter_total * QUORUM_PERCENT / PCT_SCALE)
    localparam int QUORUM_PERCENT = 67;
    localparam int PCT_SCALE      = 100;
    localparam int PCT_ROUND      = 99;
    localparam int PCT_W          = 7;

    localparam logic [2:0] REQ_TX       = 3'd0;
    localparam logic [2:0] REQ_PROPOSAL = 3'd1;
    localparam logic [2:0] REQ_VOTE     = 3'd2;
    localparam logic [2:0] REQ_CHECK    = 3'd3;
    localparam logic [2:0] REQ_COMMIT   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_NO_FINAL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TX_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOTER_TOTAL = 2'd1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_final;
        logic [7:0]  vote_total;
        logic [63:0] next_id;
        logic [31:0] tx_pending;
        logic        due;
        logic [7:0]  history_total;
    } rsp_t;

    // search token walking down the cell row
    typedef struct packed {
        logic valid;
        logic hit;
    } tok_t;

endpackage

>>> rtl/qvt_cell.sv
module qvt_cell
    import qvt_pkg::*;
#(
    parameter int CNT_W = 8,
    parameter int POS   = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tok_t             tok_in,
    output tok_t             tok_out,
    input  logic [KEY_W-1:0] key,
    input  logic             wr_en,
    input  logic [CNT_W-1:0] count
);

    localparam logic [CNT_W-1:0] POS_IDX = CNT_W'(POS);

    logic [KEY_W-1:0] stored_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             occupied;
    logic             match;

    // only slots below the vote count hold a key
    assign occupied = POS_IDX < count;
    assign match    = occupied && (stored_reg == key);

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit | (tok_in.valid & match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (count == POS_IDX))
        begin
            stored_reg <= key;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/quorum_vote_tracker.sv
// channel | direction | handshake            | word
// in      | to block  | in_valid / in_ready  | req_t: request type and 256-bit voter key
// out     | from block| out_valid / out_ready| rsp_t: status and tracker state
// cfg     | to block  | cfg_valid / cfg_ready| register index and 32-bit data
//
// a vote walks the search token down the row of key cells, one cell per cycle,
// then S_FINISH updates the state once the output register is free. every other
// request, and a vote into a full set, goes from S_EXEC straight to S_FINISH.
// reset clears all counters and marks; the key cells keep their contents.
// a result waits in the output register; a new word is taken meanwhile, but its
// update holds until that register is free.
module quorum_vote_tracker
    import qvt_pkg::*;
#(
    parameter int MAX_VOTES     = DEF_MAX_VOTES,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  req_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rsp_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int VCNT_W = $clog2(MAX_VOTES + 1);
    localparam int HIST_W = $clog2(HISTORY_DEPTH + 1);
    localparam int PROD_W = ((VCNT_W > 16) ? VCNT_W : 16) + PCT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        req_reg, req_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              hit_reg, hit_next;
    logic [VCNT_W-1:0] vote_cnt_reg, vote_cnt_next;
    logic              final_reg, final_next;
    logic [63:0]       ckpt_reg, ckpt_next;
    logic [31:0]       tx_reg, tx_next;
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [31:0]       tx_interval_reg, tx_interval_next;
    logic [15:0]       voter_total_reg, voter_total_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    logic              slot_free;
    logic              full;
    logic              search_start;
    logic              wr_en;
    logic [1:0]        status_c;
    logic [PROD_W-1:0] cnt_scaled;
    logic [PROD_W-1:0] total_scaled;
    logic              quorum_met;
    logic [VCNT_W+7:0] vote_wide;
    logic [HIST_W+7:0] hist_wide;
    tok_t              tok_link [0:MAX_VOTES];

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign slot_free    = !out_valid_reg || out_ready;
    assign full         = (vote_cnt_reg == VCNT_W'(MAX_VOTES));
    assign search_start = (state_reg == S_EXEC) && (req_reg == REQ_VOTE) && !full;

    // count >= floor(total * pct / 100) rewritten as count * 100 + 99 >= total * pct
    assign cnt_scaled   = PROD_W'(vote_cnt_reg) * PROD_W'(PCT_SCALE) + PROD_W'(PCT_ROUND);
    assign total_scaled = PROD_W'(voter_total_reg) * PROD_W'(QUORUM_PERCENT);
    assign quorum_met   = (vote_cnt_reg != '0) && (cnt_scaled >= total_scaled);

    assign tok_link[0] = '{valid: search_start, hit: 1'b0};

    for (genvar i = 0; i < MAX_VOTES; i++)
    begin : g_cell
        qvt_cell #(
            .CNT_W (VCNT_W),
            .POS   (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_link[i]),
            .tok_out (tok_link[i+1]),
            .key     (key_reg),
            .wr_en   (wr_en),
            .count   (vote_cnt_reg)
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        key_next         = key_reg;
        hit_next         = hit_reg;
        vote_cnt_next    = vote_cnt_reg;
        final_next       = final_reg;
        ckpt_next        = ckpt_reg;
        tx_next          = tx_reg;
        hist_next        = hist_reg;
        tx_interval_next = tx_interval_reg;
        voter_total_next = voter_total_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        wr_en            = 1'b0;
        status_c         = ST_OK;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TX_INTERVAL: tx_interval_next = cfg_data;
                REG_VOTER_TOTAL: voter_total_next = cfg_data[15:0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data.req_type;
                    key_next   = {in_data.key_word3, in_data.key_word2,
                                  in_data.key_word1, in_data.key_word0};
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                hit_next   = 1'b0;
                state_next = search_start ? S_SEARCH : S_FINISH;
            end
            S_SEARCH:
            begin
                if (tok_link[MAX_VOTES].valid)
                begin
                    hit_next   = tok_link[MAX_VOTES].hit;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    unique case (req_reg)
                        REQ_TX:
                        begin
                            if (tx_reg != '1)
                            begin
                                tx_next = tx_reg + 32'd1;
                            end
                        end
                        REQ_PROPOSAL:
                        begin
                            vote_cnt_next = '0;
                            final_next    = 1'b0;
                        end
                        REQ_VOTE:
                        begin
                            if (full)
                            begin
                                status_c = ST_FULL;
                            end
                            else if (hit_reg)
                            begin
                                status_c = ST_DUP;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                vote_cnt_next = vote_cnt_reg + VCNT_W'(1);
                            end
                        end
                        REQ_CHECK:
                        begin
                            if ((voter_total_reg != '0) && quorum_met)
                            begin
                                final_next = 1'b1;
                            end
                        end
                        REQ_COMMIT:
                        begin
                            if (!final_reg)
                            begin
                                status_c = ST_NO_FINAL;
                            end
                            else
                            begin
                                ckpt_next = ckpt_reg + 64'd1;
                                tx_next   = '0;
                                if (hist_reg < HIST_W'(HISTORY_DEPTH))
                                begin
                                    hist_next = hist_reg + HIST_W'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        vote_wide = {8'd0, vote_cnt_next};
        hist_wide = {8'd0, hist_next};

        if (state_reg == S_FINISH && slot_free)
        begin
            out_data_next.status        = status_c;
            out_data_next.is_final      = final_next;
            out_data_next.vote_total    = vote_wide[7:0];
            out_data_next.next_id       = ckpt_next;
            out_data_next.tx_pending    = tx_next;
            out_data_next.due           = (tx_next >= tx_interval_next);
            out_data_next.history_total = hist_wide[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            req_reg         <= '0;
            key_reg         <= '0;
            hit_reg         <= 1'b0;
            vote_cnt_reg    <= '0;
            final_reg       <= 1'b0;
            ckpt_reg        <= '0;
            tx_reg          <= '0;
            hist_reg        <= '0;
            tx_interval_reg <= '0;
            voter_total_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            key_reg         <= key_next;
            hit_reg         <= hit_next;
            vote_cnt_reg    <= vote_cnt_next;
            final_reg       <= final_next;
            ckpt_reg        <= ckpt_next;
            tx_reg          <= tx_next;
            hist_reg        <= hist_next;
            tx_interval_reg <= tx_interval_next;
            voter_total_reg <= voter_total_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

endmodule

>>> rtl/qvt_checker.sv
`include "quorum_vote_tracker_defines.svh"

module qvt_checker
    import qvt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);

    // a stalled result word stays put
    `QVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

    // one request at a time: taking a word closes the input
    `QVT_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "input open straight after accept")

    // a refused commit can only come from a proposal that is not final
    `QVT_ASSERT_SAME(a_commit_refused, out_valid && (out_data.status == ST_NO_FINAL), !out_data.is_final, "refused commit shows final mark")

endmodule

bind quorum_vote_tracker qvt_checker u_qvt_checker (.*);
